### sv/assert_macros.svh
// Assertion helpers shared by the RTL that checks itself.
// Each check is clocked on clk and held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### sv/lrle_pkg.sv
`default_nettype none

package lrle_pkg;

  // Configuration register indexes
  localparam logic REG_PATTERN_WIDTH  = 1'b0;
  localparam logic REG_PATTERN_HEIGHT = 1'b1;

  // Characters of the pattern text
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_O      = 8'h6F;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;

  // Handshake control toward the downstream register
  typedef struct packed {
    logic proc;      // byte in the input register is consumed this cycle
  } lrle_ctrl_t;

endpackage

`default_nettype wire

### sv/life_rle_run_decoder_core.sv
// Channel  Direction  Handshake              Beat payload
// in_      input      in_valid / in_ready    text_byte (8 bits)
// out_     output     out_valid / out_ready  run column, row, length, out_of_bounds, pattern_end
// cfg_     input      cfg_we                 register index, write data
//
// One byte is taken every cycle unless a held result stalls the input; each beat
// passes through an input register, the decoder state update, and a result register,
// from which the result is presented once its byte has been processed. Throughput
// is one byte per clock while no result is held.
// Reset is synchronous, active low; no clearing pass is needed.
// A stalled result holds the input register; a new byte still enters whenever
// the byte ahead of it moves on in the same cycle.
`default_nettype none

`include "assert_macros.svh"

module life_rle_run_decoder_core #(
  parameter int COORD_BITS = 12
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire  [7:0]             in_text_byte,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic [COORD_BITS-1:0]  out_run_column,
  output logic [COORD_BITS-1:0]  out_run_row,
  output logic [COORD_BITS-1:0]  out_run_length,
  output logic                   out_out_of_bounds,
  output logic                   out_pattern_end,
  input  wire                    cfg_we,
  input  wire                    cfg_index,
  input  wire  [COORD_BITS:0]    cfg_wdata
);
  import lrle_pkg::*;

  lrle_ctrl_t            ctrl;
  logic [7:0]            byte_q;
  logic                  out_free;
  logic                  res_valid, res_oob, res_end, finished;
  logic [COORD_BITS-1:0] res_column, res_row, res_length;

  assign out_free = !out_valid || out_ready;

  lrle_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_text_byte (in_text_byte),
    .out_free     (out_free),
    .ctrl         (ctrl),
    .byte_q       (byte_q)
  );

  lrle_decode #(.COORD_BITS(COORD_BITS)) u_dec (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .byte_q     (byte_q),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .res_valid  (res_valid),
    .res_column (res_column),
    .res_row    (res_row),
    .res_length (res_length),
    .res_oob    (res_oob),
    .res_end    (res_end),
    .finished   (finished)
  );

  lrle_out_stage #(.COORD_BITS(COORD_BITS)) u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl              (ctrl),
    .res_valid         (res_valid),
    .res_column        (res_column),
    .res_row           (res_row),
    .res_length        (res_length),
    .res_oob           (res_oob),
    .res_end           (res_end),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_run_column    (out_run_column),
    .out_run_row       (out_run_row),
    .out_run_length    (out_run_length),
    .out_out_of_bounds (out_out_of_bounds),
    .out_pattern_end   (out_pattern_end)
  );

  // Once finished and drained, no further result appears
  `ASSERT_NEXT(a_quiet_after_end, finished && !out_valid, !out_valid)
  // Runs always carry a nonzero length
  `ASSERT_IMPL(a_run_len, out_valid && !out_pattern_end, out_run_length != '0)
  // The end result never flags bounds
  `ASSERT_IMPL(a_end_clean, out_valid && out_pattern_end, !out_out_of_bounds)
  // Back-pressure only comes from a held result
  `ASSERT_IMPL(a_ready_cause, !in_ready, out_valid && !out_ready)

endmodule

`default_nettype wire

### sv/lrle_in_stage.sv
`default_nettype none

module lrle_in_stage (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  [7:0]            in_text_byte,
  input  wire                   out_free,
  output lrle_pkg::lrle_ctrl_t  ctrl,
  output logic [7:0]            byte_q
);
  import lrle_pkg::*;

  logic       valid_r;
  logic [7:0] byte_r;

  assign in_ready      = !valid_r || out_free;
  assign ctrl.proc     = valid_r && out_free;
  assign byte_q        = byte_r;

  // Hold a byte until the decoder consumes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (out_free) begin
      valid_r <= 1'b0;
    end
  end

  // Capture payload on every accepted beat
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_text_byte;
    end
  end

endmodule

`default_nettype wire

### sv/lrle_decode.sv
`default_nettype none

module lrle_decode #(
  parameter int COORD_BITS = 12
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  lrle_pkg::lrle_ctrl_t   ctrl,
  input  wire  [7:0]             byte_q,
  input  wire                    cfg_we,
  input  wire                    cfg_index,
  input  wire  [COORD_BITS:0]    cfg_wdata,
  output logic                   res_valid,
  output logic [COORD_BITS-1:0]  res_column,
  output logic [COORD_BITS-1:0]  res_row,
  output logic [COORD_BITS-1:0]  res_length,
  output logic                   res_oob,
  output logic                   res_end,
  output logic                   finished
);
  import lrle_pkg::*;

  localparam int W = COORD_BITS;
  localparam logic [W-1:0] CMAX = {W{1'b1}};
  localparam logic [W:0]   DIM_RESET = {1'b1, {W{1'b0}}};

  logic [W:0]   pwidth_r, pheight_r;
  logic [W-1:0] rep_r, rep_nxt;
  logic [W-1:0] col_r, col_nxt;
  logic [W-1:0] row_r, row_nxt;
  logic         at_start_r, at_start_nxt;
  logic         skip_r, skip_nxt;
  logic         fin_r, fin_nxt;

  logic [W-1:0] count;
  logic [W:0]   col_sum, row_sum;
  logic [W-1:0] col_sat, row_sat;
  logic [W+3:0] dig_val;
  logic [W-1:0] dig_sat;
  logic         is_digit;
  logic         oob;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwidth_r  <= DIM_RESET;
      pheight_r <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_WIDTH:  pwidth_r  <= cfg_wdata;
        REG_PATTERN_HEIGHT: pheight_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Count and coordinate arithmetic
  assign count    = (rep_r == '0) ? {{(W-1){1'b0}}, 1'b1} : rep_r;
  assign col_sum  = {1'b0, col_r} + {1'b0, count};
  assign row_sum  = {1'b0, row_r} + {1'b0, count};
  assign col_sat  = col_sum[W] ? CMAX : col_sum[W-1:0];
  assign row_sat  = row_sum[W] ? CMAX : row_sum[W-1:0];
  assign is_digit = (byte_q >= CH_0) && (byte_q <= CH_9);
  assign dig_val  = {rep_r, 3'b000} + {2'b00, rep_r, 1'b0} + {{W{1'b0}}, byte_q[3:0]};
  assign dig_sat  = (dig_val[W+3:W] != 4'd0) ? CMAX : dig_val[W-1:0];

  // Flag runs that leave the grid or reach the saturation limit
  assign oob = (col_sum > pwidth_r) || ({1'b0, row_r} >= pheight_r) ||
               (col_sum >= {1'b0, CMAX}) || (row_r == CMAX);

  assign res_column = col_r;
  assign res_row    = row_r;
  assign res_length = res_end ? '0 : count;
  assign res_oob    = res_end ? 1'b0 : oob;
  assign finished   = fin_r;

  // Advance the decoder state by one byte
  always_comb begin
    rep_nxt      = rep_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    at_start_nxt = at_start_r;
    skip_nxt     = skip_r;
    fin_nxt      = fin_r;
    res_valid    = 1'b0;
    res_end      = 1'b0;
    if (ctrl.proc && !fin_r) begin
      if (byte_q == CH_NL) begin
        at_start_nxt = 1'b1;
        skip_nxt     = 1'b0;
      end else begin
        at_start_nxt = 1'b0;
        if (skip_r) begin
          skip_nxt = 1'b1;
        end else if (at_start_r && (byte_q == CH_HASH || byte_q == CH_X)) begin
          skip_nxt = 1'b1;
        end else if (is_digit) begin
          rep_nxt = dig_sat;
        end else begin
          case (byte_q)
            CH_B: begin
              col_nxt = col_sat;
              rep_nxt = '0;
            end
            CH_DOLLAR: begin
              col_nxt = '0;
              row_nxt = row_sat;
              rep_nxt = '0;
            end
            CH_O: begin
              res_valid = 1'b1;
              col_nxt   = col_sat;
              rep_nxt   = '0;
            end
            CH_BANG: begin
              res_valid = 1'b1;
              res_end   = 1'b1;
              fin_nxt   = 1'b1;
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_r      <= '0;
      col_r      <= '0;
      row_r      <= '0;
      at_start_r <= 1'b1;
      skip_r     <= 1'b0;
      fin_r      <= 1'b0;
    end else begin
      rep_r      <= rep_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      at_start_r <= at_start_nxt;
      skip_r     <= skip_nxt;
      fin_r      <= fin_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/lrle_out_stage.sv
`default_nettype none

module lrle_out_stage #(
  parameter int COORD_BITS = 12
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  lrle_pkg::lrle_ctrl_t   ctrl,
  input  wire                    res_valid,
  input  wire  [COORD_BITS-1:0]  res_column,
  input  wire  [COORD_BITS-1:0]  res_row,
  input  wire  [COORD_BITS-1:0]  res_length,
  input  wire                    res_oob,
  input  wire                    res_end,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic [COORD_BITS-1:0]  out_run_column,
  output logic [COORD_BITS-1:0]  out_run_row,
  output logic [COORD_BITS-1:0]  out_run_length,
  output logic                   out_out_of_bounds,
  output logic                   out_pattern_end
);
  import lrle_pkg::*;

  logic                  valid_r;
  logic [COORD_BITS-1:0] column_r, row_r, length_r;
  logic                  oob_r, end_r;

  assign out_valid         = valid_r;
  assign out_run_column    = column_r;
  assign out_run_row       = row_r;
  assign out_run_length    = length_r;
  assign out_out_of_bounds = oob_r;
  assign out_pattern_end   = end_r;

  // Load a new result or drop the taken one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.proc) begin
      valid_r <= res_valid;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.proc && res_valid) begin
      column_r <= res_column;
      row_r    <= res_row;
      length_r <= res_length;
      oob_r    <= res_oob;
      end_r    <= res_end;
    end
  end

endmodule

`default_nettype wire

### bench/life_rle_run_decoder_checker.sv
// Watches the byte and result channels, decodes the accepted text on its own
// and compares every result beat field by field with the oldest pending run.
module life_rle_run_decoder_checker #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [7:0]            in_text_byte,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [COORD_BITS-1:0] out_run_column,
  input  logic [COORD_BITS-1:0] out_run_row,
  input  logic [COORD_BITS-1:0] out_run_length,
  input  logic                  out_out_of_bounds,
  input  logic                  out_pattern_end,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [COORD_BITS:0]   cfg_wdata,
  output int                    fail_count,
  output int                    pending_runs,
  output int                    bytes_seen,
  output int                    runs_seen,
  output int                    oob_seen,
  output int                    ends_seen
);
  import lrle_pkg::*;

  localparam int CMAX = (1 << COORD_BITS) - 1;

  typedef struct packed {
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] length;
    logic                  oob;
    logic                  pat_end;
  } run_beat_t;

  run_beat_t run_q[$];

  // Shadow of the grid registers and of the decoder state
  int grid_w;
  int grid_h;
  int rep_cnt;
  int cur_col;
  int cur_row;
  bit line_start;
  bit skip_line;
  bit done;

  function automatic int sat_coord(int v);
    return (v > CMAX) ? CMAX : v;
  endfunction

  function automatic void check_field(string name, logic [COORD_BITS-1:0] want,
                                      logic [COORD_BITS-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Advance the decoder by one text byte; queue the run or end beat it causes
  task automatic decode_byte(input logic [7:0] c);
    bit        first;
    int        cnt;
    int        endc;
    run_beat_t beat;
    if (done) return;
    if (c == CH_NL) begin
      line_start = 1'b1;
      skip_line  = 1'b0;
      return;
    end
    first      = line_start;
    line_start = 1'b0;
    if (skip_line) return;
    if (first && (c == CH_HASH || c == CH_X)) begin
      skip_line = 1'b1;
      return;
    end
    if (c >= CH_0 && c <= CH_9) begin
      rep_cnt = sat_coord(rep_cnt * 10 + int'(c - CH_0));
      return;
    end
    cnt = (rep_cnt != 0) ? rep_cnt : 1;
    case (c)
      CH_B: begin
        cur_col = sat_coord(cur_col + cnt);
        rep_cnt = 0;
      end
      CH_DOLLAR: begin
        cur_col = 0;
        cur_row = sat_coord(cur_row + cnt);
        rep_cnt = 0;
      end
      CH_O: begin
        endc         = cur_col + cnt;
        beat.column  = COORD_BITS'(cur_col);
        beat.row     = COORD_BITS'(cur_row);
        beat.length  = COORD_BITS'(cnt);
        beat.oob     = (endc > grid_w) || (cur_row >= grid_h) ||
                       (endc >= CMAX) || (cur_row >= CMAX);
        beat.pat_end = 1'b0;
        run_q.push_back(beat);
        cur_col = sat_coord(endc);
        rep_cnt = 0;
      end
      CH_BANG: begin
        beat.column  = COORD_BITS'(cur_col);
        beat.row     = COORD_BITS'(cur_row);
        beat.length  = '0;
        beat.oob     = 1'b0;
        beat.pat_end = 1'b1;
        run_q.push_back(beat);
        done = 1'b1;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    run_beat_t want;
    if (!rst_n) begin
      grid_w     = 4096;
      grid_h     = 4096;
      rep_cnt    = 0;
      cur_col    = 0;
      cur_row    = 0;
      line_start = 1'b1;
      skip_line  = 1'b0;
      done       = 1'b0;
      run_q.delete();
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_PATTERN_WIDTH:  grid_w = int'(cfg_wdata);
          REG_PATTERN_HEIGHT: grid_h = int'(cfg_wdata);
          default: ;
        endcase
      end
      // Compare the result beat with the oldest pending run
      if (out_valid && out_ready) begin
        if (run_q.size() == 0) begin
          $error("result beat with no run pending: column %0d row %0d length %0d",
                 out_run_column, out_run_row, out_run_length);
          fail_count++;
        end else begin
          want = run_q.pop_front();
          check_field("run_column", want.column, out_run_column);
          check_field("run_row", want.row, out_run_row);
          check_field("run_length", want.length, out_run_length);
          check_field("out_of_bounds", COORD_BITS'(want.oob),
                      COORD_BITS'(out_out_of_bounds));
          check_field("pattern_end", COORD_BITS'(want.pat_end),
                      COORD_BITS'(out_pattern_end));
          if (want.pat_end) ends_seen++;
          else runs_seen++;
          if (want.oob) oob_seen++;
        end
      end
      // Decode the accepted byte
      if (in_valid && in_ready) begin
        bytes_seen++;
        decode_byte(in_text_byte);
      end
    end
    pending_runs <= run_q.size();
  end

endmodule

### bench/tb_life_rle_run_decoder_core.sv
module tb_life_rle_run_decoder_core;
  import lrle_pkg::*;

  localparam int COORD_BITS      = 12;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_BYTES     = 250;
  localparam int NUM_PHASES      = 5;
  // Two register stages from accept to result, plus margin
  localparam int SETTLE_CYCLES   = 4;
  localparam int TAIL_CYCLES     = 8;

  logic                  clk;
  logic                  rst_n        = 1'b0;
  logic                  in_valid     = 1'b0;
  logic [7:0]            in_text_byte = 8'h00;
  logic                  out_ready    = 1'b0;
  logic                  cfg_we       = 1'b0;
  logic                  cfg_index    = 1'b0;
  logic [COORD_BITS:0]   cfg_wdata    = '0;
  logic                  in_ready;
  logic                  out_valid;
  logic [COORD_BITS-1:0] out_run_column;
  logic [COORD_BITS-1:0] out_run_row;
  logic [COORD_BITS-1:0] out_run_length;
  logic                  out_out_of_bounds;
  logic                  out_pattern_end;

  int   fail_count;
  int   pending_runs;
  int   bytes_seen;
  int   runs_seen;
  int   oob_seen;
  int   ends_seen;

  int   idle_pct  = 0;
  int   stall_pct = 0;
  logic hold_req  = 1'b0;
  int   hold_left = 0;
  int   bytes_sent = 0;

  life_rle_run_decoder_core #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_text_byte      (in_text_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_run_column    (out_run_column),
    .out_run_row       (out_run_row),
    .out_run_length    (out_run_length),
    .out_out_of_bounds (out_out_of_bounds),
    .out_pattern_end   (out_pattern_end),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  life_rle_run_decoder_checker #(
    .COORD_BITS(COORD_BITS)
  ) run_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_text_byte      (in_text_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_run_column    (out_run_column),
    .out_run_row       (out_run_row),
    .out_run_length    (out_run_length),
    .out_out_of_bounds (out_out_of_bounds),
    .out_pattern_end   (out_pattern_end),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .fail_count        (fail_count),
    .pending_runs      (pending_runs),
    .bytes_seen        (bytes_seen),
    .runs_seen         (runs_seen),
    .oob_seen          (oob_seen),
    .ends_seen         (ends_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: hold off for a long stretch on request, else stall at random
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= HOLD_OFF_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Drop the run if no beat moves on either channel for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
    $display("FAIL life_rle_run_decoder_core");
    $finish;
  end

  // Offer one byte after a random gap and hold it until accepted
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_text_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Pause the sender until every run has come out and the pipe is empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_runs != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_grid(input logic [COORD_BITS:0] w, input logic [COORD_BITS:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PATTERN_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= REG_PATTERN_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly well-formed count/symbol tokens; some newlines, skipped lines, noise
  task automatic send_random_piece();
    int         pick;
    int         ndig;
    logic [7:0] b;
    logic [7:0] sym;
    pick = $urandom_range(99);
    if (pick < 5) begin
      b = 8'($urandom_range(255));
      // keep the end mark for the close of the run
      if (b == CH_BANG) b = CH_NL;
      send_byte(b);
    end else if (pick < 9) begin
      send_byte(CH_NL);
    end else if (pick < 12) begin
      send_byte(CH_NL);
      send_byte($urandom_range(1) ? CH_HASH : CH_X);
      repeat ($urandom_range(6)) begin
        b = 8'($urandom_range(255));
        if (b == CH_NL) b = CH_O;
        send_byte(b);
      end
      send_byte(CH_NL);
    end else begin
      pick = $urandom_range(99);
      sym  = (pick < 45) ? CH_O : (pick < 75) ? CH_B : CH_DOLLAR;
      // keep row growth small so the row stays inside the grid for most runs
      if (sym == CH_DOLLAR) begin
        ndig = $urandom_range(1);
      end else begin
        pick = $urandom_range(99);
        ndig = (pick < 50) ? 0 : (pick < 80) ? 1 : (pick < 95) ? 2 : 4;
      end
      repeat (ndig) send_byte(8'(CH_0 + $urandom_range(9)));
      send_byte(sym);
    end
  endtask

  initial begin
    int ph;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    set_grid(13'd4096, 13'd4096);

    // Skipped comment and header lines, extreme bytes, marks mid-line,
    // count kept across a newline, count and column saturation
    send_text("#o!\nxo\n");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("o#x3\no99999bo2$");

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          set_grid(13'($urandom_range(200, 8)), 13'($urandom_range(500, 20)));
          idle_pct  = 0;
          stall_pct <= 0;
          // long receiver hold-off while the sender keeps offering bytes
          hold_req <= 1'b1;
          @(posedge clk);
          hold_req <= 1'b0;
        end
        1: begin
          set_grid(13'd1, 13'd8191);
          idle_pct  = 68;
          stall_pct <= 0;
        end
        2: begin
          set_grid(13'd8191, 13'd0);
          idle_pct  = 0;
          stall_pct <= 68;
        end
        3: begin
          set_grid(13'd0, 13'd1);
          idle_pct  = 8;
          stall_pct <= 8;
        end
        default: begin
          set_grid(13'($urandom_range(200, 8)), 13'($urandom_range(600, 100)));
          idle_pct  = 0;
          stall_pct <= 0;
        end
      endcase
      while (bytes_sent < 24 + (ph + 1) * PHASE_BYTES) send_random_piece();
    end

    // Row saturation, the end mark, then bytes that must be ignored
    send_text("9999$o!o\n#3b");
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Decoded %0d bytes into %0d runs, %0d out of grid, %0d end beat(s)",
             bytes_seen, runs_seen, oob_seen, ends_seen);
    $display("Covered grids of 0, 1, 4096, 8191 and random size under idle and stall traffic");
    if (fail_count == 0) begin
      $display("PASS life_rle_run_decoder_core");
    end else begin
      $display("FAIL life_rle_run_decoder_core");
    end
    $finish;
  end

endmodule
